// ----- hdl/h2r_pkg.sv -----
`default_nettype none

package h2r_pkg;

    // Field widths
    localparam int HUE_W       = 12;
    localparam int SAT_W       = 11;
    localparam int INT_W       = 11;
    localparam int LEVEL_W     = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;

    // Hue handling
    localparam int HUE_WRAP    = 3600;
    localparam int SECTOR_SPAN = 1200;
    localparam int HN_W        = 11;
    localparam int SAT_FULL    = 1024;
    localparam int IN_FRAC     = 10;
    localparam int LEVEL_MAX   = 255;

    // q table banking: 5 banks of 240 entries cover one sector
    localparam int BANK_COUNT  = 5;
    localparam int BANK_DEPTH  = 240;
    localparam int BANK_W      = 3;
    localparam int IDX_W       = 8;

    // Trig constants (Q30)
    localparam longint unsigned Q30_ONE       = 64'd1 << 30;
    localparam longint unsigned RAD_PER_TENTH = 64'd1874033;

    // Sector, named by its lead channel
    typedef enum logic [2:0] {
        SECT_RED   = 3'b001,
        SECT_GREEN = 3'b010,
        SECT_BLUE  = 3'b100
    } sector_t;

    // Shift-subtract divide, elaboration use only
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem    = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint cos_series(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        x2  = (x * x) >> 30;
        t   = Q30_ONE;
        sum = longint'(t);
        for (int k = 1; k <= 6; k++)
        begin
            t = udiv64((t * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if (k % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        return sum;
    endfunction

    function automatic longint sin_series(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(t);
        for (int k = 1; k <= 6; k++)
        begin
            t = udiv64((t * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            if (k % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        return sum;
    endfunction

    // Cosine in Q30 of an angle in tenths of a degree, 0..1200
    function automatic longint cos_tenths(int a);
        longint r;
        if (a <= 600)
            r = cos_series(64'(a) * RAD_PER_TENTH);
        else if (a <= 900)
            r = sin_series(64'(900 - a) * RAD_PER_TENTH);
        else
            r = -sin_series(64'(a - 900) * RAD_PER_TENTH);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/hsi_to_rgb_converter_core.sv -----
`default_nettype none

// HSI to RGB pixel converter. Takes one pixel word per clock and returns one RGB word
// for each, through its registered stages: one input stage for hue wrap,
// saturation clamp and sector split, three stages for the banked q = cos(H)/cos(60-H)
// ratio table, two multiply/truncate pairs for S*q, I*(1-S) and I*(1+S*q) with the
// third channel formed in the second truncate stage, and the output register that
// scales by 255, rounds and saturates. The whole pipe holds on output backpressure;
// tready follows it.
// FRAC_BITS (10..24) sets the internal fixed point and the table contents.
module hsi_to_rgb_converter_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // hue_tenths[11:0], saturation_frac[22:12], intensity_frac[33:23], zero pad
    input  wire logic [h2r_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // red_level[7:0], green_level[15:8], blue_level[23:16]
    output logic [h2r_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // clipped[0]
    output logic [h2r_pkg::OUT_TUSER_W-1:0]        m_axis_tuser
);
    import h2r_pkg::*;

    localparam int STAGES = 9;
    localparam int QW     = FRAC_BITS + 3;
    localparam int XW     = FRAC_BITS + 1;       // S and I in Q(F)
    localparam int PSW    = 2 * FRAC_BITS + 5;   // S*q product
    localparam int PGW    = 2 * XW;              // I*(1-S) product
    localparam int PLW    = 2 * FRAC_BITS + 6;   // I*(1+S*q) product
    localparam int CW     = FRAC_BITS + 5;       // channel, signed
    localparam int VW     = FRAC_BITS + 12;      // channel * 255
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int RND    = (1 << FRAC_BITS) - 1;
    localparam int HALF   = 1 << (FRAC_BITS - 1);

    logic                adv;
    logic [STAGES-1:0]   vld_next, vld_reg;

    // Stage 1
    logic [HUE_W-1:0]    hue_in, hue_w;
    logic [SAT_W-1:0]    sat_in, sat_c;
    logic [INT_W-1:0]    int_in;
    logic [HN_W-1:0]     hn_next, hn_reg;
    sector_t             sect_next;
    sector_t             sect_reg [1:8];
    logic [SAT_W-1:0]    sat_reg  [1:4];
    logic [INT_W-1:0]    int_reg  [1:4];

    // Stages 4..8
    logic signed [QW-1:0]  q;
    logic [XW-1:0]         sq4, iq4, one_minus;
    logic signed [PSW-1:0] prod_sq_next, prod_sq_reg;
    logic [PGW-1:0]        prod_lag_next, prod_lag_reg;
    logic [XW-1:0]         iq_reg [5:7];
    logic [PSW-1:0]        adj_sq;
    logic [QW-1:0]         sqp_next, sqp_reg;
    logic [XW-1:0]         lag_next, lag_reg6, lag_reg7, lag_reg8;
    logic [QW:0]           one_plus;
    logic signed [PLW-1:0] prod_lead_next, prod_lead_reg;
    logic [PLW-1:0]        adj_lead;
    logic [FRAC_BITS+3:0]  lead_s;
    logic [FRAC_BITS+2:0]  lead_next, lead_reg;
    logic [CW-1:0]         third_next, third_reg;

    // Stage 9
    logic [CW-1:0]         ch [3];
    logic [VW-1:0]         scaled [3];
    logic [LEVEL_W-1:0]    lvl_next [3];
    logic [LEVEL_W-1:0]    lvl_reg  [3];
    logic                  clip_next, clip_reg;

    // Pipe advances unless the output word is stalled
    assign adv           = !vld_reg[STAGES-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign vld_next      = {vld_reg[STAGES-2:0], s_axis_tvalid};

    // Stage 1: wrap, clamp, sector split
    always_comb
    begin
        hue_in = s_axis_tdata[HUE_W-1:0];
        sat_in = s_axis_tdata[HUE_W +: SAT_W];
        int_in = s_axis_tdata[HUE_W+SAT_W +: INT_W];
        hue_w  = (hue_in >= HUE_W'(HUE_WRAP)) ? hue_in - HUE_W'(HUE_WRAP) : hue_in;
        sat_c  = (sat_in > SAT_W'(SAT_FULL)) ? SAT_W'(SAT_FULL) : sat_in;
        if (hue_w >= HUE_W'(2 * SECTOR_SPAN))
        begin
            sect_next = SECT_BLUE;
            hn_next   = HN_W'(hue_w - HUE_W'(2 * SECTOR_SPAN));
        end
        else if (hue_w >= HUE_W'(SECTOR_SPAN))
        begin
            sect_next = SECT_GREEN;
            hn_next   = HN_W'(hue_w - HUE_W'(SECTOR_SPAN));
        end
        else
        begin
            sect_next = SECT_RED;
            hn_next   = HN_W'(hue_w);
        end
    end

    h2r_qrom #(
        .FRAC_BITS (FRAC_BITS)
    ) u_qrom (
        .clk (clk),
        .adv (adv),
        .hn  (hn_reg),
        .q   (q)
    );

    // Stage 5: S*q and I*(1-S)
    always_comb
    begin
        sq4           = XW'(sat_reg[4]) << (FRAC_BITS - IN_FRAC);
        iq4           = XW'(int_reg[4]) << (FRAC_BITS - IN_FRAC);
        one_minus     = XW'(ONE) - sq4;
        prod_sq_next  = $signed({1'b0, sq4}) * q;
        prod_lag_next = iq4 * one_minus;
    end

    // Stage 6: truncate toward zero
    always_comb
    begin
        adj_sq   = prod_sq_reg + (prod_sq_reg[PSW-1] ? PSW'(RND) : PSW'(0));
        sqp_next = adj_sq[FRAC_BITS +: QW];
        lag_next = prod_lag_reg[FRAC_BITS +: XW];
    end

    // Stage 7: I*(1+S*q)
    always_comb
    begin
        one_plus       = (QW+1)'(ONE) + {sqp_reg[QW-1], sqp_reg};
        prod_lead_next = $signed({1'b0, iq_reg[6]}) * $signed(one_plus);
    end

    // Stage 8: lead clamp and third channel
    always_comb
    begin
        adj_lead   = prod_lead_reg + (prod_lead_reg[PLW-1] ? PLW'(RND) : PLW'(0));
        lead_s     = adj_lead[FRAC_BITS +: FRAC_BITS+4];
        lead_next  = lead_s[FRAC_BITS+3] ? '0 : lead_s[FRAC_BITS+2:0];
        third_next = (CW'(iq_reg[7]) << 1) + CW'(iq_reg[7]) - CW'(lead_next) - CW'(lag_reg7);
    end

    // Stage 9: channel order, scale, round, saturate
    always_comb
    begin
        case (sect_reg[8])
            SECT_RED:
            begin
                ch[0] = CW'(lead_reg); ch[1] = third_reg;       ch[2] = CW'(lag_reg8);
            end
            SECT_GREEN:
            begin
                ch[0] = CW'(lag_reg8); ch[1] = CW'(lead_reg);   ch[2] = third_reg;
            end
            SECT_BLUE:
            begin
                ch[0] = third_reg;     ch[1] = CW'(lag_reg8);   ch[2] = CW'(lead_reg);
            end
            default:
            begin
                ch[0] = CW'(lead_reg); ch[1] = third_reg;       ch[2] = CW'(lag_reg8);
            end
        endcase
        clip_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            scaled[k] = VW'(ch[k][CW-2:0]) * VW'(LEVEL_MAX) + VW'(HALF);
            if (ch[k][CW-1])
                lvl_next[k] = '0;
            else if (scaled[k][VW-1:FRAC_BITS] > 12'(LEVEL_MAX))
            begin
                lvl_next[k] = LEVEL_W'(LEVEL_MAX);
                clip_next   = 1'b1;
            end
            else
                lvl_next[k] = scaled[k][FRAC_BITS +: LEVEL_W];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Payload pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hn_reg        <= hn_next;
            sect_reg[1]   <= sect_next;
            sat_reg[1]    <= sat_c;
            int_reg[1]    <= int_in;
            for (int s = 2; s <= 4; s++)
            begin
                sat_reg[s] <= sat_reg[s-1];
                int_reg[s] <= int_reg[s-1];
            end
            for (int s = 2; s <= 8; s++)
                sect_reg[s] <= sect_reg[s-1];
            prod_sq_reg   <= prod_sq_next;
            prod_lag_reg  <= prod_lag_next;
            iq_reg[5]     <= iq4;
            sqp_reg       <= sqp_next;
            lag_reg6      <= lag_next;
            iq_reg[6]     <= iq_reg[5];
            prod_lead_reg <= prod_lead_next;
            lag_reg7      <= lag_reg6;
            iq_reg[7]     <= iq_reg[6];
            lead_reg      <= lead_next;
            third_reg     <= third_next;
            lag_reg8      <= lag_reg7;
            lvl_reg       <= lvl_next;
            clip_reg      <= clip_next;
        end
    end

    assign m_axis_tvalid = vld_reg[STAGES-1];
    assign m_axis_tdata  = {lvl_reg[2], lvl_reg[1], lvl_reg[0]};
    assign m_axis_tuser  = clip_reg;

    // Assertions
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted word did not enter stage 1");

    a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (lvl_reg[0] == LEVEL_W'(LEVEL_MAX) || lvl_reg[1] == LEVEL_W'(LEVEL_MAX) ||
             lvl_reg[2] == LEVEL_W'(LEVEL_MAX)))
        else $error("clip set without a saturated channel");

    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (q <= $signed(QW'(2 * ONE)) && q >= -$signed(QW'(ONE))))
        else $error("table ratio out of range");

endmodule

`default_nettype wire

// ----- hdl/h2r_qrom.sv -----
`default_nettype none

// Ratio table q(hn) = cos(hn) / cos(60 - hn) in Q(FRAC_BITS), three register stages
module h2r_qrom #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          adv,
    input  wire logic [h2r_pkg::HN_W-1:0]      hn,
    output logic signed [FRAC_BITS+2:0]        q
);
    import h2r_pkg::*;

    localparam int QW = FRAC_BITS + 3;

    function automatic logic [QW-1:0] q_entry(int h);
        longint c1;
        longint c2;
        longint num;
        longint mag;
        int     d;
        logic   neg;
        c1  = cos_tenths(h);
        d   = (h <= 600) ? (600 - h) : (h - 600);
        c2  = cos_tenths(d);
        if (c2 <= 0)
            c2 = 1;
        num = c1 <<< FRAC_BITS;
        neg = (num < 0);
        mag = longint'(udiv64(64'(neg ? -num : num), 64'(c2)));
        return QW'(neg ? -mag : mag);
    endfunction

    function automatic logic [BANK_DEPTH*QW-1:0] bank_bits(int b);
        logic [BANK_DEPTH*QW-1:0] r;
        r = '0;
        for (int j = 0; j < BANK_DEPTH; j++)
            r[j*QW +: QW] = q_entry(b * BANK_DEPTH + j);
        return r;
    endfunction

    localparam logic [BANK_DEPTH*QW-1:0] BANK0 = bank_bits(0);
    localparam logic [BANK_DEPTH*QW-1:0] BANK1 = bank_bits(1);
    localparam logic [BANK_DEPTH*QW-1:0] BANK2 = bank_bits(2);
    localparam logic [BANK_DEPTH*QW-1:0] BANK3 = bank_bits(3);
    localparam logic [BANK_DEPTH*QW-1:0] BANK4 = bank_bits(4);

    logic [BANK_W-1:0] bank_next, bank_reg, bank_b_reg;
    logic [IDX_W-1:0]  idx_next, idx_reg;
    logic [QW-1:0]     rd_reg [BANK_COUNT];
    logic [QW-1:0]     q_next, q_reg;

    // Stage A: bank and offset
    always_comb
    begin
        if (hn >= HN_W'(4 * BANK_DEPTH))
            bank_next = BANK_W'(4);
        else if (hn >= HN_W'(3 * BANK_DEPTH))
            bank_next = BANK_W'(3);
        else if (hn >= HN_W'(2 * BANK_DEPTH))
            bank_next = BANK_W'(2);
        else if (hn >= HN_W'(BANK_DEPTH))
            bank_next = BANK_W'(1);
        else
            bank_next = BANK_W'(0);
        idx_next = IDX_W'(hn - HN_W'(int'(bank_next) * BANK_DEPTH));
    end

    // Stage C: bank select
    always_comb
    begin
        case (bank_b_reg)
            BANK_W'(0): q_next = rd_reg[0];
            BANK_W'(1): q_next = rd_reg[1];
            BANK_W'(2): q_next = rd_reg[2];
            BANK_W'(3): q_next = rd_reg[3];
            BANK_W'(4): q_next = rd_reg[4];
            default:    q_next = rd_reg[0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bank_reg   <= bank_next;
            idx_reg    <= idx_next;
            // Stage B: one read per bank
            rd_reg[0]  <= BANK0[int'(idx_reg)*QW +: QW];
            rd_reg[1]  <= BANK1[int'(idx_reg)*QW +: QW];
            rd_reg[2]  <= BANK2[int'(idx_reg)*QW +: QW];
            rd_reg[3]  <= BANK3[int'(idx_reg)*QW +: QW];
            rd_reg[4]  <= BANK4[int'(idx_reg)*QW +: QW];
            bank_b_reg <= bank_reg;
            q_reg      <= q_next;
        end
    end

    assign q = $signed(q_reg);

endmodule

`default_nettype wire

// ----- bench/tb_hsi_to_rgb_converter_core.sv -----
`default_nettype none

module tb_hsi_to_rgb_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import h2r_pkg::*;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 2000;
    localparam int MAX_CYC   = 600000;
    localparam int TAIL_CYC  = 30;
    localparam longint unsigned ANG_STEP = 64'd1874033;
    localparam longint unsigned ONE_Q30  = 64'd1 << 30;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic               clip;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [INT_W-1:0] inten;
        logic             typed;
        rgb_t             want;
    } vec_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    rgb_t pending_rgb[$];
    int   mismatches = 0;
    int   words_in = 0;
    int   words_out = 0;
    int   cycles = 0;
    bit   hold_done = 1'b0;

    hsi_to_rgb_converter_core #(.FRAC_BITS(FRAC)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock and reset
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Taylor series, Q30, every term floored
    function automatic longint taylor_cos(longint unsigned x);
        longint unsigned xx;
        longint unsigned term;
        longint          acc;
        xx   = (x * x) >> 30;
        term = ONE_Q30;
        acc  = longint'(term);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * xx) >> 30) / longint'((2 * k - 1) * (2 * k));
            acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        return acc;
    endfunction

    function automatic longint taylor_sin(longint unsigned x);
        longint unsigned xx;
        longint unsigned term;
        longint          acc;
        xx   = (x * x) >> 30;
        term = x;
        acc  = longint'(term);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * xx) >> 30) / longint'((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        return acc;
    endfunction

    // cosine of 0..1200 tenths; past 60 degrees via sine of the complement
    function automatic longint cos_of_tenths(int ang);
        longint r;
        if (ang <= 600)
            r = taylor_cos(longint'(ang) * ANG_STEP);
        else if (ang <= 900)
            r = taylor_sin(longint'(900 - ang) * ANG_STEP);
        else
            r = -taylor_sin(longint'(ang - 900) * ANG_STEP);
        return r;
    endfunction

    // channel value to 8-bit level, round half up, saturate
    function automatic logic [LEVEL_W-1:0] chan_level(longint c, inout logic clip);
        longint v;
        if (c < 0)
            return '0;
        v = (c * 255 + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (v > LEVEL_MAX)
        begin
            clip = 1'b1;
            return LEVEL_W'(LEVEL_MAX);
        end
        return LEVEL_W'(v);
    endfunction

    function automatic rgb_t hsi_to_rgb(logic [HUE_W-1:0] hue_in, logic [SAT_W-1:0] sat_in,
                                        logic [INT_W-1:0] int_in);
        int     h;
        int     sect;
        int     hn;
        int     hdist;
        longint one;
        longint sq;
        longint iq;
        longint cn;
        longint cd;
        longint ratio;
        longint sratio;
        longint lead;
        longint lag;
        longint third;
        longint ch[3];
        rgb_t   res;
        logic   clip;
        one = longint'(1) << FRAC;
        h   = hue_in;
        if (h >= HUE_WRAP)
            h -= HUE_WRAP;
        sq   = (sat_in > SAT_FULL) ? SAT_FULL : sat_in;
        sq   = sq << (FRAC - IN_FRAC);
        iq   = longint'(int_in) << (FRAC - IN_FRAC);
        sect = h / SECTOR_SPAN;
        hn   = h - sect * SECTOR_SPAN;
        hdist = (hn <= 600) ? 600 - hn : hn - 600;
        cn   = cos_of_tenths(hn);
        cd   = cos_of_tenths(hdist);
        if (cd <= 0)
            cd = 1;
        ratio  = (cn * one) / cd;
        sratio = (sq * ratio) / one;
        lag    = (iq * (one - sq)) / one;
        lead   = (iq * (one + sratio)) / one;
        if (lead < 0)
            lead = 0;
        third = 3 * iq - lead - lag;
        case (sect)
            0:       begin ch[0] = lead;  ch[1] = third; ch[2] = lag;   end
            1:       begin ch[0] = lag;   ch[1] = lead;  ch[2] = third; end
            default: begin ch[0] = third; ch[1] = lag;   ch[2] = lead;  end
        endcase
        clip      = 1'b0;
        res.red   = chan_level(ch[0], clip);
        res.green = chan_level(ch[1], clip);
        res.blue  = chan_level(ch[2], clip);
        res.clip  = clip;
        return res;
    endfunction

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one pixel word, hold until taken, then log its expected result
    task automatic send_pixel(vec_t v, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, v.inten, v.sat, v.hue};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_in++;
        pending_rgb.push_back(v.typed ? v.want : hsi_to_rgb(v.hue, v.sat, v.inten));
    endtask

    // sender: directed table, then random pixels
    initial
    begin
        vec_t dir_tbl[$];
        vec_t v;
        int   r;
        // black, full gray, overdriven gray (clips), then the hue edges
        dir_tbl.push_back('{12'd0, 11'd0, 11'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}});
        dir_tbl.push_back('{12'd1234, 11'd0, 11'd1024, 1'b1,
                            '{8'd255, 8'd255, 8'd255, 1'b0}});
        dir_tbl.push_back('{12'd4095, 11'd0, 11'd2047, 1'b1,
                            '{8'd255, 8'd255, 8'd255, 1'b1}});
        dir_tbl.push_back('{12'd0, 11'd1024, 11'd512, 1'b0, '0});
        dir_tbl.push_back('{12'd600, 11'd1024, 11'd512, 1'b0, '0});
        dir_tbl.push_back('{12'd1199, 11'd1024, 11'd512, 1'b0, '0});
        dir_tbl.push_back('{12'd1200, 11'd1024, 11'd512, 1'b0, '0});
        dir_tbl.push_back('{12'd2399, 11'd1024, 11'd512, 1'b0, '0});
        dir_tbl.push_back('{12'd2400, 11'd1024, 11'd512, 1'b0, '0});
        dir_tbl.push_back('{12'd3599, 11'd1024, 11'd512, 1'b0, '0});
        // hue wrap
        dir_tbl.push_back('{12'd3600, 11'd700, 11'd300, 1'b0, '0});
        dir_tbl.push_back('{12'd4095, 11'd700, 11'd300, 1'b0, '0});
        // saturation clamp
        dir_tbl.push_back('{12'd900, 11'd1025, 11'd600, 1'b0, '0});
        dir_tbl.push_back('{12'd900, 11'd2047, 11'd600, 1'b0, '0});
        // bright saturated pixels that clip, plus one dim, nearly gray pixel
        dir_tbl.push_back('{12'd0, 11'd1024, 11'd1024, 1'b0, '0});
        dir_tbl.push_back('{12'd1800, 11'd512, 11'd2047, 1'b0, '0});
        dir_tbl.push_back('{12'd3000, 11'd1, 11'd1, 1'b0, '0});
        dir_tbl.push_back('{12'd2047, 11'd1023, 11'd1023, 1'b0, '0});

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        foreach (dir_tbl[k])
            send_pixel(dir_tbl[k], pick_gap());

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // one pause until the pipe is fully drained
            if (n == 1000)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_rgb.size() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 9);
            v.hue   = (r == 0) ? HUE_W'($urandom) : HUE_W'($urandom_range(0, 3599));
            r = $urandom_range(0, 9);
            v.sat   = (r == 0) ? SAT_W'($urandom) : SAT_W'($urandom_range(0, 1024));
            r = $urandom_range(0, 9);
            v.inten = (r == 0) ? INT_W'($urandom) : INT_W'($urandom_range(0, 1024));
            v.typed = 1'b0;
            v.want  = '0;
            send_pixel(v, (n >= 300 && n < 500) ? 0 : pick_gap());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (mismatches == 0 && pending_rgb.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver backpressure, with one long hold-off mid run
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && words_in >= 600)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            stall = (words_in >= 1200 && words_in < 1400) ? 0 : pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        rgb_t want;
        rgb_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tuser[0]};
            if (pending_rgb.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %0d: %h", words_out, got);
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word %0d: exp r=%0d g=%0d b=%0d clip=%0b, ",
                                  "got r=%0d g=%0d b=%0d clip=%0b"},
                                 words_out, want.red, want.green, want.blue, want.clip,
                                 got.red, got.green, got.blue, got.clip);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

`default_nettype wire
